/* hdl/cts_pkg.sv */
// shared codes and types for the cooperative task scheduler
package cts_pkg;

  // input word kinds
  localparam logic [1:0] KIND_SPAWN  = 2'd0;
  localparam logic [1:0] KIND_SCAN   = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  // report codes
  localparam logic [1:0] RPT_STOP    = 2'd0;
  localparam logic [1:0] RPT_ERROR   = 2'd1;
  localparam logic [1:0] RPT_SUSPEND = 2'd2;
  localparam logic [1:0] RPT_JOIN    = 2'd3;

  // result kinds
  localparam logic [2:0] RES_SPAWNED     = 3'd0;
  localparam logic [2:0] RES_REFUSED     = 3'd1;
  localparam logic [2:0] RES_DISPATCH    = 3'd2;
  localparam logic [2:0] RES_SWEEP_DONE  = 3'd3;
  localparam logic [2:0] RES_EMPTY       = 3'd4;
  localparam logic [2:0] RES_REPORT_OK   = 3'd5;
  localparam logic [2:0] RES_JOIN_REFUSE = 3'd6;

  // spawn refusal reasons
  localparam logic [1:0] RSN_DELAY = 2'd0;
  localparam logic [1:0] RSN_FULL  = 2'd1;
  localparam logic [1:0] RSN_IDS   = 2'd2;

  // verdict on the slot at the head of the ring
  typedef struct packed {
    logic        fire;
    logic        upd_min;
    logic [30:0] wait_ms;
  } cts_eval_t;

endpackage

/* hdl/cts_cell.sv */
// one slot cell of the rotating ring
module cts_cell import cts_pkg::*; #(
  parameter int CW = 41
) (
  input  logic          clk,
  input  logic [CW-1:0] nb_d,
  input  logic          wr_en,
  input  logic [CW-1:0] wr_d,
  output logic [CW-1:0] d_out
);

  logic [CW-1:0] d_r;

  // take the neighbor's slot, or new contents on a write
  always_ff @(posedge clk) begin
    d_r <= wr_en ? wr_d : nb_d;
  end

  assign d_out = d_r;

endmodule

/* hdl/cts_eval.sv */
// evaluates the slot at the head cell during a sweep
module cts_eval import cts_pkg::*; (
  input  logic        joining,
  input  logic [31:0] wait_value,
  input  logic [31:0] now_ms,
  input  logic [30:0] min_wait,
  input  logic        target_gone,
  output cts_eval_t   res
);

  logic [31:0] diff;
  logic        due;

  always_comb begin
    diff = wait_value - now_ms;
    due  = (diff == 32'd0) || diff[31];
    res.fire    = joining ? target_gone : due;
    res.upd_min = !joining && !due && ((min_wait == 31'd0) || (diff[30:0] < min_wait));
    res.wait_ms = diff[30:0];
  end

endmodule

/* hdl/cooperative_task_scheduler.sv */
// cooperative round-robin task scheduler, top level
// results: refusals, stop/error reports and empty scans are registered straight from idle;
//   spawn and suspend/join reports wait for the slot's cell to rotate to the head
// scan: waits for the cursor's slot at the head, then walks ids to a dispatch or sweep end
// throughput: one item at a time; next word taken once the result word has left
// reset: rst_n synchronous active low, clears window, cursor, alive bits; max_delay all ones
module cooperative_task_scheduler import cts_pkg::*; #(
  parameter int QUEUE_SIZE   = 8,
  parameter int MIN_TASK_ID  = 1,
  parameter int MAX_TASK_ID  = 65534,
  parameter int HANDLE_WIDTH = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  // input channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,  // delay_ms[30:0] handle[38:31] now_ms[70:39]
                                  // report_code[72:71] report_value[104:73] zero pad
  input  logic [1:0]   in_tuser,  // kind
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata, // task_id[15:0] task_handle[23:16] min_wait_ms[54:24]
                                  // refuse_reason[56:55] zero pad
  output logic [2:0]   out_tuser, // result_kind
  // configuration
  input  logic         cfg_wr_en,
  input  logic [30:0]  cfg_wr_data // max_delay
);

  localparam int SW = (QUEUE_SIZE > 1) ? $clog2(QUEUE_SIZE) : 1;
  localparam int IW = 17;                 // ids up to MAX_TASK_ID + 1
  localparam int CW = 1 + 32 + HANDLE_WIDTH; // joining, wake value, handle
  localparam logic [SW-1:0] MIN_SLOT = SW'(MIN_TASK_ID % QUEUE_SIZE);
  localparam logic [SW-1:0] LAST_SLOT = SW'(QUEUE_SIZE - 1);
  localparam logic [SW:0]   Q_EXT = (SW+1)'(QUEUE_SIZE);
  localparam logic [IW-1:0] MIN_ID = IW'(MIN_TASK_ID);
  localparam logic [IW-1:0] MAX_ID = IW'(MAX_TASK_ID);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WRITE} state_t;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  // input field unpacking
  logic [1:0]  f_kind;
  logic [30:0] f_delay;
  logic [7:0]  f_handle;
  logic [31:0] f_now, f_value;
  logic [1:0]  f_code;
  logic [15:0] f_handle_ext;
  assign f_kind       = in_tuser;
  assign f_delay      = in_tdata[30:0];
  assign f_handle     = in_tdata[38:31];
  assign f_now        = in_tdata[70:39];
  assign f_code       = in_tdata[72:71];
  assign f_value      = in_tdata[104:73];
  assign f_handle_ext = {8'd0, f_handle};

  // control state
  state_t          state_r, state_nxt;
  logic [30:0]     max_delay_r;
  logic [IW-1:0]   first_r, first_nxt, next_r, next_nxt, cur_r, cur_nxt, disp_r, disp_nxt;
  logic [SW-1:0]   first_slot_r, first_slot_nxt, next_slot_r, next_slot_nxt;
  logic [SW-1:0]   cur_slot_r, cur_slot_nxt, disp_slot_r, disp_slot_nxt;
  logic [SW-1:0]   head_r;
  logic            run_r, run_nxt;
  logic [30:0]     min_r, min_nxt;
  logic [QUEUE_SIZE-1:0] alive_r, alive_nxt;
  logic            out_valid_r, out_valid_nxt;

  // pending cell write and scan time
  logic [SW-1:0]   wr_slot_r, wr_slot_nxt;
  logic            wr_join_r, wr_join_nxt;
  logic            wr_keep_r, wr_keep_nxt;
  logic [31:0]     wr_wait_r, wr_wait_nxt;
  logic [HANDLE_WIDTH-1:0] wr_hdl_r, wr_hdl_nxt;
  logic [31:0]     now_r, now_nxt;

  // result word payload
  logic [2:0]  out_kind_r, out_kind_nxt;
  logic [15:0] out_id_r, out_id_nxt;
  logic [7:0]  out_hdl_r, out_hdl_nxt;
  logic [30:0] out_min_r, out_min_nxt;
  logic [1:0]  out_rsn_r, out_rsn_nxt;

  // ring of cells: cell 0 holds slot head_r, rotating by one every cycle
  logic [CW-1:0] cell_q [QUEUE_SIZE];
  logic          tail_wr;
  logic [CW-1:0] tail_d;

  for (genvar i = 0; i < QUEUE_SIZE; i++) begin : g_cell
    if (i == QUEUE_SIZE - 1) begin : g_tail
      cts_cell #(.CW(CW)) u_cell (
        .clk(clk), .nb_d(cell_q[0]), .wr_en(tail_wr), .wr_d(tail_d), .d_out(cell_q[i])
      );
    end else begin : g_body
      cts_cell #(.CW(CW)) u_cell (
        .clk(clk), .nb_d(cell_q[i+1]), .wr_en(1'b0), .wr_d(tail_d), .d_out(cell_q[i])
      );
    end
  end

  logic                    head_join;
  logic [31:0]             head_wait;
  logic [HANDLE_WIDTH-1:0] head_hdl;
  assign {head_join, head_wait, head_hdl} = cell_q[0];

  // join target check: in window and its slot still alive
  logic [31:0] tgt_off;
  logic [SW:0] tgt_sum;
  logic [SW-1:0] tgt_slot;
  logic        tgt_in_win, tgt_gone;
  always_comb begin
    tgt_in_win = (head_wait >= {15'd0, first_r}) && (head_wait < {15'd0, next_r});
    tgt_off    = head_wait - {15'd0, first_r};
    tgt_sum    = {1'b0, first_slot_r} + tgt_off[SW:0];
    if (tgt_sum >= Q_EXT) tgt_sum = tgt_sum - Q_EXT;
    tgt_slot   = tgt_sum[SW-1:0];
    tgt_gone   = !tgt_in_win || !alive_r[tgt_slot];
  end

  cts_eval_t ev;
  cts_eval u_eval (
    .joining(head_join), .wait_value(head_wait), .now_ms(now_r), .min_wait(min_r),
    .target_gone(tgt_gone), .res(ev)
  );

  logic [15:0] hdl_out_ext;
  assign hdl_out_ext = 16'(head_hdl);

  logic disp_live;
  assign disp_live = (disp_r >= first_r) && (disp_r < next_r) && alive_r[disp_slot_r];

  assign in_tready = (state_r == ST_IDLE) && !out_valid_r;
  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    state_nxt      = state_r;
    first_nxt      = first_r;
    next_nxt       = next_r;
    cur_nxt        = cur_r;
    disp_nxt       = disp_r;
    first_slot_nxt = first_slot_r;
    next_slot_nxt  = next_slot_r;
    cur_slot_nxt   = cur_slot_r;
    disp_slot_nxt  = disp_slot_r;
    run_nxt        = run_r;
    min_nxt        = min_r;
    alive_nxt      = alive_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    wr_slot_nxt    = wr_slot_r;
    wr_join_nxt    = wr_join_r;
    wr_keep_nxt    = wr_keep_r;
    wr_wait_nxt    = wr_wait_r;
    wr_hdl_nxt     = wr_hdl_r;
    now_nxt        = now_r;
    out_kind_nxt   = out_kind_r;
    out_id_nxt     = out_id_r;
    out_hdl_nxt    = out_hdl_r;
    out_min_nxt    = out_min_r;
    out_rsn_nxt    = out_rsn_r;
    tail_wr        = 1'b0;
    tail_d         = {wr_join_r, wr_wait_r, wr_keep_r ? head_hdl : wr_hdl_r};

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_id_nxt  = '0;
          out_hdl_nxt = '0;
          out_min_nxt = '0;
          out_rsn_nxt = '0;
          unique case (f_kind)
            KIND_SPAWN: begin
              out_kind_nxt = RES_REFUSED;
              if (f_delay > max_delay_r) begin
                out_rsn_nxt   = RSN_DELAY;
                out_valid_nxt = 1'b1;
              end else if ((next_r - first_r) >= IW'(QUEUE_SIZE)) begin
                out_rsn_nxt   = RSN_FULL;
                out_valid_nxt = 1'b1;
              end else if (next_r > MAX_ID) begin
                out_rsn_nxt   = RSN_IDS;
                out_valid_nxt = 1'b1;
              end else begin
                out_kind_nxt = RES_SPAWNED;
                out_id_nxt   = next_r[15:0];
                alive_nxt[next_slot_r] = 1'b1;
                wr_slot_nxt  = next_slot_r;
                wr_join_nxt  = 1'b0;
                wr_keep_nxt  = 1'b0;
                wr_wait_nxt  = run_r ? ({1'b0, f_delay} + f_now) : {1'b0, f_delay};
                wr_hdl_nxt   = f_handle_ext[HANDLE_WIDTH-1:0];
                next_nxt      = next_r + 1'b1;
                next_slot_nxt = slot_inc(next_slot_r);
                state_nxt    = ST_WRITE;
              end
            end
            KIND_SCAN: begin
              run_nxt = 1'b1;
              now_nxt = f_now;
              if (first_r == next_r) begin
                cur_nxt       = first_r;
                cur_slot_nxt  = first_slot_r;
                min_nxt       = '0;
                out_kind_nxt  = RES_EMPTY;
                out_valid_nxt = 1'b1;
              end else begin
                if (cur_r < first_r) begin
                  cur_nxt      = first_r;
                  cur_slot_nxt = first_slot_r;
                end
                state_nxt = ST_SCAN;
              end
            end
            KIND_REPORT: begin
              out_id_nxt   = disp_r[15:0];
              out_kind_nxt = RES_REPORT_OK;
              wr_slot_nxt  = disp_slot_r;
              wr_keep_nxt  = 1'b1;
              wr_wait_nxt  = f_value;
              if (disp_live) begin
                priority if (f_code == RPT_STOP || f_code == RPT_ERROR) begin
                  alive_nxt[disp_slot_r] = 1'b0;
                  out_valid_nxt = 1'b1;
                end else if (f_code == RPT_SUSPEND) begin
                  wr_join_nxt = 1'b0;
                  state_nxt   = ST_WRITE;
                end else if ({15'd0, disp_r} >= f_value) begin
                  out_kind_nxt  = RES_JOIN_REFUSE;
                  out_valid_nxt = 1'b1;
                end else begin
                  wr_join_nxt = 1'b1;
                  state_nxt   = ST_WRITE;
                end
              end
            end
            KIND_CLEAR: begin
              first_nxt      = MIN_ID;
              next_nxt       = MIN_ID;
              cur_nxt        = MIN_ID;
              first_slot_nxt = MIN_SLOT;
              next_slot_nxt  = MIN_SLOT;
              cur_slot_nxt   = MIN_SLOT;
              disp_nxt       = '0;
              disp_slot_nxt  = '0;
              run_nxt        = 1'b0;
              min_nxt        = '0;
              alive_nxt      = '0;
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        if (cur_r >= next_r) begin
          // sweep ran off the end of the window
          out_kind_nxt  = RES_SWEEP_DONE;
          out_min_nxt   = min_r;
          out_valid_nxt = 1'b1;
          cur_nxt       = first_r;
          cur_slot_nxt  = first_slot_r;
          min_nxt       = '0;
          state_nxt     = ST_IDLE;
        end else if (cur_slot_r == head_r) begin
          cur_nxt      = cur_r + 1'b1;
          cur_slot_nxt = slot_inc(cur_slot_r);
          if (!alive_r[cur_slot_r]) begin
            // collect a dead slot at the head of the window
            if (cur_r == first_r) begin
              first_nxt      = first_r + 1'b1;
              first_slot_nxt = slot_inc(first_slot_r);
            end
          end else if (ev.fire) begin
            disp_nxt      = cur_r;
            disp_slot_nxt = cur_slot_r;
            out_kind_nxt  = RES_DISPATCH;
            out_id_nxt    = cur_r[15:0];
            out_hdl_nxt   = hdl_out_ext[7:0];
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else if (ev.upd_min) begin
            min_nxt = ev.wait_ms;
          end
        end
      end

      ST_WRITE: begin
        // slot reaches the head cell: rewrite it on its way to the tail
        if (wr_slot_r == head_r) begin
          tail_wr       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      max_delay_r  <= 31'h7FFF_FFFF;
      first_r      <= MIN_ID;
      next_r       <= MIN_ID;
      cur_r        <= MIN_ID;
      disp_r       <= '0;
      first_slot_r <= MIN_SLOT;
      next_slot_r  <= MIN_SLOT;
      cur_slot_r   <= MIN_SLOT;
      disp_slot_r  <= '0;
      head_r       <= '0;
      run_r        <= 1'b0;
      min_r        <= '0;
      alive_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_wr_en) max_delay_r <= cfg_wr_data;
      first_r      <= first_nxt;
      next_r       <= next_nxt;
      cur_r        <= cur_nxt;
      disp_r       <= disp_nxt;
      first_slot_r <= first_slot_nxt;
      next_slot_r  <= next_slot_nxt;
      cur_slot_r   <= cur_slot_nxt;
      disp_slot_r  <= disp_slot_nxt;
      head_r       <= slot_inc(head_r);
      run_r        <= run_nxt;
      min_r        <= min_nxt;
      alive_r      <= alive_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    wr_slot_r  <= wr_slot_nxt;
    wr_join_r  <= wr_join_nxt;
    wr_keep_r  <= wr_keep_nxt;
    wr_wait_r  <= wr_wait_nxt;
    wr_hdl_r   <= wr_hdl_nxt;
    now_r      <= now_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_hdl_r  <= out_hdl_nxt;
    out_min_r  <= out_min_nxt;
    out_rsn_r  <= out_rsn_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {7'd0, out_rsn_r, out_min_r, out_hdl_r, out_id_r};

  // window never inverts
  a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
    first_r <= next_r) else $error("task window inverted");

  // window never holds more ids than slots
  a_window_size: assert property (@(posedge clk) disable iff (!rst_n)
    (next_r - first_r) <= IW'(QUEUE_SIZE)) else $error("task window overflow");

  // a sweep never walks behind the head of the window
  a_cursor_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (cur_r >= first_r)) else $error("sweep cursor behind head");

endmodule
